>>> rtl/sppid_pkg.sv
// Package: item, configuration and state types for the servo position PID step.
package sppid_pkg;

    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP_GAIN,
        REG_KI_GAIN,
        REG_KD_GAIN,
        REG_KI_SHIFT,
        REG_KD_SHIFT,
        REG_PWM_LIMIT,
        REG_WRAP_THRESHOLD,
        REG_COUNTER_SPAN
    } t_reg_index;

    localparam logic signed [15:0] KP_GAIN_RST        = 16'sd100;
    localparam logic signed [15:0] KI_GAIN_RST        = 16'sd25;
    localparam logic signed [15:0] KD_GAIN_RST        = 16'sd20000;
    localparam logic [4:0]         KI_SHIFT_RST       = 5'd5;
    localparam logic [4:0]         KD_SHIFT_RST       = 5'd4;
    localparam logic [15:0]        PWM_LIMIT_RST      = 16'd1023;
    localparam logic [15:0]        WRAP_THRESHOLD_RST = 16'd32767;
    localparam logic [16:0]        COUNTER_SPAN_RST   = 17'd65536;

    typedef struct packed {
        logic [9:0]  ref_sample;
        logic [15:0] encoder_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        pwm_forward;
        logic [15:0]        pwm_reverse;
        logic               saturated;
        logic signed [15:0] drive_value;
        logic signed [15:0] position;
        logic signed [15:0] filtered_reference;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] kp_gain;
        logic signed [15:0] ki_gain;
        logic signed [15:0] kd_gain;
        logic [4:0]         ki_shift;
        logic [4:0]         kd_shift;
        logic [15:0]        pwm_limit;
        logic [15:0]        wrap_threshold;
        logic [16:0]        counter_span;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] reference_filter;
        logic signed [15:0] error_sum;
        logic signed [15:0] previous_error;
    } t_state;

endpackage

>>> rtl/sppid_step.sv
// One control tick: filter, position, PID terms, clamp with anti-windup, PWM split.
module sppid_step (
    input  sppid_pkg::t_in_item  i_item,
    input  sppid_pkg::t_cfg      i_cfg,
    input  sppid_pkg::t_state    i_state,
    output sppid_pkg::t_out_item o_result,
    output sppid_pkg::t_state    o_state_next
);

    logic [15:0]        pos_u;
    logic [19:0]        rf_x;
    logic [19:0]        filt7;
    logic signed [15:0] filt;
    logic signed [15:0] position;
    logic signed [15:0] err;
    logic signed [15:0] esum;
    logic signed [15:0] diff;
    logic signed [31:0] prod_p;
    logic signed [31:0] prod_i;
    logic signed [31:0] prod_d;
    logic signed [31:0] term_i;
    logic signed [31:0] term_d;
    logic signed [31:0] sum;
    logic signed [31:0] lim;
    logic signed [31:0] neg_lim;
    logic               sat_hi;
    logic               sat_lo;
    logic               sat;
    logic signed [31:0] drive;
    logic signed [31:0] neg_drive;

    always_comb begin
        if (i_item.encoder_count > i_cfg.wrap_threshold) begin
            pos_u = i_item.encoder_count - i_cfg.counter_span[15:0];
        end else begin
            pos_u = i_item.encoder_count;
        end
        position = $signed(pos_u);

        // 7/8 low-pass: (7*f + sample) >>> 3, low 16 bits
        rf_x  = {{4{i_state.reference_filter[15]}}, i_state.reference_filter};
        filt7 = (rf_x << 3) - rf_x + {10'd0, i_item.ref_sample};
        filt  = $signed(filt7[18:3]);

        err  = filt - position;
        esum = i_state.error_sum + err;
        diff = err - i_state.previous_error;

        prod_p = i_cfg.kp_gain * err;
        prod_i = i_cfg.ki_gain * esum;
        prod_d = i_cfg.kd_gain * diff;
        term_i = prod_i >>> i_cfg.ki_shift;
        term_d = prod_d >>> i_cfg.kd_shift;
        sum    = prod_p + term_i + term_d;

        lim     = $signed({16'd0, i_cfg.pwm_limit});
        neg_lim = -lim;
        sat_hi  = sum > lim;
        sat_lo  = sum < neg_lim;
        sat     = sat_hi | sat_lo;
        if (sat_hi) begin
            drive = lim;
        end else if (sat_lo) begin
            drive = neg_lim;
        end else begin
            drive = sum;
        end
        neg_drive = -drive;

        o_result.pwm_forward        = drive[31] ? 16'd0 : drive[15:0];
        o_result.pwm_reverse        = drive[31] ? neg_drive[15:0] : 16'd0;
        o_result.saturated          = sat;
        o_result.drive_value        = $signed(drive[15:0]);
        o_result.position           = position;
        o_result.filtered_reference = filt;

        // anti-windup: taking the error back out leaves the old sum
        o_state_next.reference_filter = filt;
        o_state_next.error_sum        = sat ? i_state.error_sum : esum;
        o_state_next.previous_error   = err;
    end

endmodule

>>> rtl/servo_position_pid_step.sv
// Top level: servo position PID step with input register, result register and config.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one control tick:
//   a 10-bit reference sample and a 16-bit encoder counter value. An item is
//   taken at a rising edge with valid high and stall low.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns one result
//   per item: forward/reverse duty, saturation flag, clamped drive, position
//   and filtered reference.
//   An accepted item is held in the input register and its result then in the
//   result register. Throughput: one item per cycle while the receiver does not
//   stall; the whole step, including the integral update with its clamp feedback,
//   is one combinational pass between the input register and the result register.
//   When the receiver stalls, the result holds and the input register still
//   takes one more item; the input side then stalls until the result moves.
//   Reset clears filter, integral and previous error to zero, loads the register
//   defaults and empties both stages. Configuration writes (i_cfg_we, i_cfg_index,
//   i_cfg_data) take effect at the next edge; the user must make them only while
//   no item is in flight, since the block itself does not enforce this.
module servo_position_pid_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  sppid_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output sppid_pkg::t_out_item                  o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [sppid_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sppid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    sppid_pkg::t_cfg      r_cfg;
    sppid_pkg::t_cfg      n_cfg;
    sppid_pkg::t_state    r_state;
    sppid_pkg::t_state    n_state;
    sppid_pkg::t_in_item  r_in_item;
    logic                 r_in_valid;
    sppid_pkg::t_out_item r_out_item;
    logic                 r_out_valid;
    sppid_pkg::t_out_item step_result;
    logic                 in_take;
    logic                 out_move;

    assign out_move   = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~out_move;
    assign in_take    = i_in_valid & ~o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    sppid_step u_step (
        .i_item       (r_in_item),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_result     (step_result),
        .o_state_next (n_state)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (sppid_pkg::t_reg_index'(i_cfg_index))
                sppid_pkg::REG_KP_GAIN:        n_cfg.kp_gain        = $signed(i_cfg_data[15:0]);
                sppid_pkg::REG_KI_GAIN:        n_cfg.ki_gain        = $signed(i_cfg_data[15:0]);
                sppid_pkg::REG_KD_GAIN:        n_cfg.kd_gain        = $signed(i_cfg_data[15:0]);
                sppid_pkg::REG_KI_SHIFT:       n_cfg.ki_shift       = i_cfg_data[4:0];
                sppid_pkg::REG_KD_SHIFT:       n_cfg.kd_shift       = i_cfg_data[4:0];
                sppid_pkg::REG_PWM_LIMIT:      n_cfg.pwm_limit      = i_cfg_data[15:0];
                sppid_pkg::REG_WRAP_THRESHOLD: n_cfg.wrap_threshold = i_cfg_data[15:0];
                sppid_pkg::REG_COUNTER_SPAN:   n_cfg.counter_span   = i_cfg_data[16:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain        <= sppid_pkg::KP_GAIN_RST;
            r_cfg.ki_gain        <= sppid_pkg::KI_GAIN_RST;
            r_cfg.kd_gain        <= sppid_pkg::KD_GAIN_RST;
            r_cfg.ki_shift       <= sppid_pkg::KI_SHIFT_RST;
            r_cfg.kd_shift       <= sppid_pkg::KD_SHIFT_RST;
            r_cfg.pwm_limit      <= sppid_pkg::PWM_LIMIT_RST;
            r_cfg.wrap_threshold <= sppid_pkg::WRAP_THRESHOLD_RST;
            r_cfg.counter_span   <= sppid_pkg::COUNTER_SPAN_RST;
            r_state              <= '0;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (out_move) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_move) begin
                r_in_valid <= 1'b0;
            end
            if (out_move) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (out_move) begin
            r_out_item <= step_result;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.pwm_forward == 16'd0 || o_out_item.pwm_reverse == 16'd0))
        else $error("forward and reverse duty both active");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.saturated) |->
            ($unsigned(o_out_item.drive_value) == r_cfg.pwm_limit ||
             $unsigned(o_out_item.drive_value) == 16'(-r_cfg.pwm_limit)))
        else $error("saturated drive not at limit");

endmodule
